[rtl/core/dual_dimmer_button_link_controller_defines.svh]
// Assertion macros used by the dimmer controller RTL (the result sequencer).
`ifndef DUAL_DIMMER_BUTTON_LINK_CONTROLLER_DEFINES_SVH
`define DUAL_DIMMER_BUTTON_LINK_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check, skipped while reset is high.
`define DDBLC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define DDBLC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DDBLC_ASSERT(label, clk, rst, prop, msg)
`define DDBLC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[rtl/core/ddblc_pkg.sv]
// Shared types, constants and helpers of the dimmer controller.
`timescale 1ns / 1ps
package ddblc_pkg;

   localparam int Channels = 2;

   // request operations
   localparam logic [1:0] OpTick  = 2'd0;
   localparam logic [1:0] OpLink  = 2'd1;
   localparam logic [1:0] OpPower = 2'd2;
   localparam logic [1:0] OpLevel = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CsrDebounce = 2'd0;
   localparam logic [1:0] CsrRepeat   = 2'd1;
   localparam logic [1:0] CsrBlink    = 2'd2;
   localparam logic [1:0] CsrLongHold = 2'd3;

   localparam logic [9:0]  DebounceReset = 10'd30;
   localparam logic [10:0] RepeatReset   = 11'd300;
   localparam logic [7:0]  BlinkReset    = 8'd0;
   localparam logic [7:0]  LongHoldReset = 8'd50;

   localparam logic [7:0] MarkStart    = 8'h24;
   localparam logic [7:0] MarkEnd      = 8'h23;
   localparam int         BarStep      = 30;
   localparam logic [7:0] CountAtReset = 8'd60;

   // frame byte slots
   localparam logic [2:0] SlotStart = 3'd0;
   localparam logic [2:0] SlotLevel0 = 3'd1;
   localparam logic [2:0] SlotLevel1 = 3'd2;
   localparam logic [2:0] SlotBar0  = 3'd3;
   localparam logic [2:0] SlotBar1  = 3'd4;
   localparam logic [2:0] SlotEnd   = 3'd5;

   typedef struct packed {
      logic [9:0]  debounce_ms;
      logic [10:0] repeat_ms;
      logic [7:0]  blink_rate;
      logic [7:0]  long_hold_max;
   } cfg_type;

   typedef struct packed {
      logic invoke;
      logic opt_set;
   } btn_evt_type;

   // everything the emitter needs to replay one request's results
   typedef struct packed {
      logic [1:0] nf;
      logic [1:0] first_power;
      logic [1:0] power;
      logic [7:0] level0;
      logic [7:0] level1;
      logic       led;
      logic       option;
      logic       toggled;
   } desc_type;

   // (level + 30) / 30 for an 8-bit level: one plus the thresholds passed
   function automatic logic [7:0] bar_of(logic [7:0] lv);
      logic [3:0] cnt;
      cnt = 4'd1;
      for (int k = 1; k <= 8; k++) begin
         if (lv >= 8'(k * BarStep)) cnt = cnt + 4'd1;
      end
      return {4'b0000, cnt};
   endfunction

endpackage

[rtl/core/ddblc_button.sv]
// Debounce and auto-repeat tracking of one button.
`timescale 1ns / 1ps
module ddblc_button (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick_en,
   input  logic                   raw,
   input  ddblc_pkg::cfg_type     cfg,
   output ddblc_pkg::btn_evt_type evt
);

   logic        raw_prev_ff, raw_prev_in;
   logic        deb_ff, deb_in;
   logic [15:0] stable_ff, stable_in;
   logic [15:0] rpt_ticks_ff, rpt_ticks_in;
   logic [7:0]  rpt_cnt_ff, rpt_cnt_in;
   logic        fast_ff, fast_in;
   logic [11:0] period;

   always_comb begin
      raw_prev_in  = raw;
      deb_in       = deb_ff;
      fast_in      = fast_ff;
      rpt_cnt_in   = rpt_cnt_ff;
      evt.invoke   = 1'b0;
      evt.opt_set  = 1'b0;
      rpt_ticks_in = (rpt_ticks_ff != 16'hFFFF) ? rpt_ticks_ff + 16'd1 : rpt_ticks_ff;
      if (raw != raw_prev_ff) stable_in = 16'd0;
      else if (stable_ff != 16'hFFFF) stable_in = stable_ff + 16'd1;
      else stable_in = stable_ff;
      period = fast_ff ? {1'b0, cfg.repeat_ms} : {cfg.repeat_ms, 1'b0};

      if (stable_in > {6'd0, cfg.debounce_ms}) begin
         if (raw != deb_ff) begin
            deb_in = raw;
            if (!raw) begin
               rpt_ticks_in = 16'd0;
               rpt_cnt_in   = 8'd0;
            end else if (rpt_cnt_ff != 8'd0) begin
               evt.opt_set = (rpt_cnt_ff <= cfg.long_hold_max) && (rpt_cnt_ff > 8'd1);
            end else begin
               evt.invoke = 1'b1;
               fast_in    = 1'b0;
            end
         end else if (!deb_ff) begin
            if (rpt_ticks_in > {4'd0, period}) begin
               rpt_ticks_in = 16'd0;
               if (rpt_cnt_ff != 8'hFF) rpt_cnt_in = rpt_cnt_ff + 8'd1;
               fast_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff  <= 1'b0;
         deb_ff       <= 1'b0;
         stable_ff    <= 16'd0;
         rpt_ticks_ff <= 16'd0;
         rpt_cnt_ff   <= ddblc_pkg::CountAtReset;
         fast_ff      <= 1'b0;
      end else if (tick_en) begin
         raw_prev_ff  <= raw_prev_in;
         deb_ff       <= deb_in;
         stable_ff    <= stable_in;
         rpt_ticks_ff <= rpt_ticks_in;
         rpt_cnt_ff   <= rpt_cnt_in;
         fast_ff      <= fast_in;
      end
   end

endmodule

[rtl/core/ddblc_state.sv]
// Power, level, link parser, blinker and option state; builds the result descriptor.
`timescale 1ns / 1ps
module ddblc_state (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [1:0]           operation,
   input  logic                 button_a,
   input  logic                 button_b,
   input  logic                 channel,
   input  logic [7:0]           value,
   input  ddblc_pkg::cfg_type   cfg,
   output ddblc_pkg::desc_type  desc
);

   localparam logic [1:0] PhaseHunt  = 2'd0;
   localparam logic [1:0] PhaseFirst = 2'd1;
   localparam logic [1:0] PhaseSecond = 2'd2;
   localparam logic [1:0] PhaseSkip  = 2'd3;

   ddblc_pkg::btn_evt_type evt [ddblc_pkg::Channels];
   logic [ddblc_pkg::Channels-1:0] raw;
   logic [ddblc_pkg::Channels-1:0] invoke;
   logic [ddblc_pkg::Channels-1:0] opt_set;
   logic tick_en;

   logic [1:0]  power_ff, power_in;
   logic [7:0]  level_ff [ddblc_pkg::Channels];
   logic [7:0]  level_in [ddblc_pkg::Channels];
   logic [1:0]  phase_ff, phase_in;
   logic [11:0] blink_ff, blink_in;
   logic        led_ff, led_in;
   logic        option_ff, option_in;
   logic [7:0]  link_level;

   assign raw     = {button_b, button_a};
   assign tick_en = step && (operation == ddblc_pkg::OpTick);

   for (genvar i = 0; i < ddblc_pkg::Channels; i++) begin : g_btn
      ddblc_button u_button (
         .clock   (clock),
         .reset   (reset),
         .tick_en (tick_en),
         .raw     (raw[i]),
         .cfg     (cfg),
         .evt     (evt[i])
      );
      assign invoke[i]  = evt[i].invoke;
      assign opt_set[i] = evt[i].opt_set;
   end

   assign link_level = {value[6:0], 1'b0};

   always_comb begin
      power_in  = power_ff;
      level_in  = level_ff;
      phase_in  = phase_ff;
      blink_in  = blink_ff;
      led_in    = led_ff;
      option_in = option_ff;
      desc      = '0;

      unique case (operation)
         ddblc_pkg::OpTick: begin
            power_in         = power_ff ^ invoke;
            desc.nf          = {1'b0, invoke[0]} + {1'b0, invoke[1]};
            desc.toggled     = |invoke;
            option_in        = option_ff | (|opt_set);
            blink_in = (blink_ff != 12'hFFF) ? blink_ff + 12'd1 : blink_ff;
            if ((cfg.blink_rate != 8'd0) && (blink_in > {cfg.blink_rate, 4'b0000})) begin
               blink_in = 12'd0;
               led_in   = ~led_ff;
            end
         end
         ddblc_pkg::OpLink: begin
            unique case (phase_ff)
               PhaseHunt: begin
                  if (value == ddblc_pkg::MarkStart) phase_in = PhaseFirst;
               end
               PhaseFirst: begin
                  phase_in = PhaseSecond;
                  if (level_ff[0] != link_level) begin
                     level_in[0] = link_level;
                     desc.nf     = 2'd1;
                  end
               end
               PhaseSecond: begin
                  phase_in = PhaseSkip;
                  if (level_ff[1] != link_level) begin
                     level_in[1] = link_level;
                     desc.nf     = 2'd1;
                  end
               end
               PhaseSkip: phase_in = PhaseHunt;
               default: phase_in = PhaseHunt;
            endcase
         end
         ddblc_pkg::OpPower: begin
            if (power_ff[channel] != value[0]) begin
               power_in[channel] = value[0];
               desc.nf           = 2'd1;
            end
         end
         ddblc_pkg::OpLevel: begin
            if (level_ff[channel] != value) begin
               level_in[channel] = value;
               desc.nf           = 2'd1;
            end
         end
         default: ;
      endcase

      // first frame of a tick carries channel 0's change alone
      if ((operation == ddblc_pkg::OpTick) && invoke[0])
         desc.first_power = {power_ff[1], ~power_ff[0]};
      else
         desc.first_power = power_in;
      desc.power  = power_in;
      desc.level0 = level_in[0];
      desc.level1 = level_in[1];
      desc.led    = led_in;
      desc.option = option_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff  <= 2'b00;
         phase_ff  <= PhaseHunt;
         blink_ff  <= 12'd0;
         led_ff    <= 1'b0;
         option_ff <= 1'b0;
         for (int i = 0; i < ddblc_pkg::Channels; i++) level_ff[i] <= 8'd0;
      end else if (step) begin
         power_ff  <= power_in;
         phase_ff  <= phase_in;
         blink_ff  <= blink_in;
         led_ff    <= led_in;
         option_ff <= option_in;
         for (int i = 0; i < ddblc_pkg::Channels; i++) level_ff[i] <= level_in[i];
      end
   end

endmodule

[rtl/core/ddblc_emit.sv]
// Result register and sequencer: frame bytes of a request, then its status result.
`timescale 1ns / 1ps
`include "dual_dimmer_button_link_controller_defines.svh"
module ddblc_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  ddblc_pkg::desc_type load_desc,
   output logic                load_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_kind,
   output logic [7:0]          rsp_frame_byte,
   output logic                rsp_last,
   output logic                rsp_led_on,
   output logic                rsp_option_seen,
   output logic                rsp_toggled
);

   logic                valid_ff, valid_in;
   ddblc_pkg::desc_type desc_ff, desc_in;
   logic [1:0]          frm_ff, frm_in;
   logic [2:0]          pos_ff, pos_in;
   logic                is_status;
   logic                take;
   logic                load;
   logic [1:0]          snap_power;

   assign is_status  = (frm_ff == desc_ff.nf);
   assign take       = valid_ff && !rsp_stall;
   assign load_ready = !valid_ff || (take && is_status);
   assign load       = load_valid && load_ready;
   assign snap_power = (frm_ff == 2'd0) ? desc_ff.first_power : desc_ff.power;

   always_comb begin
      valid_in = valid_ff;
      desc_in  = desc_ff;
      frm_in   = frm_ff;
      pos_in   = pos_ff;
      if (load) begin
         valid_in = 1'b1;
         desc_in  = load_desc;
         frm_in   = 2'd0;
         pos_in   = ddblc_pkg::SlotStart;
      end else if (take) begin
         if (is_status) begin
            valid_in = 1'b0;
         end else if (pos_ff == ddblc_pkg::SlotEnd) begin
            pos_in = ddblc_pkg::SlotStart;
            frm_in = frm_ff + 2'd1;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_comb begin
      rsp_frame_byte = 8'd0;
      if (!is_status) begin
         unique case (pos_ff)
            ddblc_pkg::SlotStart:  rsp_frame_byte = ddblc_pkg::MarkStart;
            ddblc_pkg::SlotLevel0: rsp_frame_byte = {snap_power[0], desc_ff.level0[7:1]};
            ddblc_pkg::SlotLevel1: rsp_frame_byte = {snap_power[1], desc_ff.level1[7:1]};
            ddblc_pkg::SlotBar0:   rsp_frame_byte = ddblc_pkg::bar_of(desc_ff.level0);
            ddblc_pkg::SlotBar1:   rsp_frame_byte = ddblc_pkg::bar_of(desc_ff.level1);
            ddblc_pkg::SlotEnd:    rsp_frame_byte = ddblc_pkg::MarkEnd;
            default:               rsp_frame_byte = 8'd0;
         endcase
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = !is_status;
   assign rsp_last        = is_status;
   assign rsp_led_on      = desc_ff.led;
   assign rsp_option_seen = desc_ff.option;
   assign rsp_toggled     = desc_ff.toggled;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         frm_ff   <= 2'd0;
         pos_ff   <= ddblc_pkg::SlotStart;
      end else begin
         valid_ff <= valid_in;
         frm_ff   <= frm_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

   `DDBLC_ASSERT(a_frame_in_range, clock, reset, valid_ff |-> (frm_ff <= desc_ff.nf), "frame index past frame count")
   `DDBLC_ASSERT(a_slot_in_range, clock, reset, valid_ff |-> (pos_ff <= ddblc_pkg::SlotEnd), "frame slot out of range")
   `DDBLC_ASSERT(a_status_at_slot0, clock, reset, (valid_ff && is_status) |-> (pos_ff == ddblc_pkg::SlotStart), "status result with frame slot pending")
   `DDBLC_ASSERT(a_drain_empties, clock, reset, (take && is_status && !load_valid) |=> !valid_ff, "result register kept after last result")
   `DDBLC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !valid_ff, "result register valid after reset")

endmodule

[rtl/core/dual_dimmer_button_link_controller.sv]
// Top level of the two-channel dimmer controller: ports, config registers, input register.
`timescale 1ns / 1ps
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   req      | req_valid/req_stall, operation..value   | in
//   rsp      | rsp_valid/rsp_stall, kind..toggled      | out
//   csr      | csr_we, csr_addr, csr_wdata             | in
//
// A request is registered; when it leaves the input register it updates all state
// and loads the result register with a descriptor of its results in the same
// cycle. The sequencer then shows 1, 7 or 13 results (frame bytes of zero, one
// or two frames, then the status result), one per cycle while rsp_stall is low;
// the output port sets the rate of requests.
// The next request is taken while the current results drain.
// Synchronous active-high reset clears state, restores the config defaults
// and empties both registers. rsp_stall holds the shown result; req_stall
// rises only when the input register holds a request that cannot advance.
module dual_dimmer_button_link_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic        req_button_a,
   input  logic        req_button_b,
   input  logic        req_channel,
   input  logic [7:0]  req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last,
   output logic        rsp_led_on,
   output logic        rsp_option_seen,
   output logic        rsp_toggled,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [10:0] csr_wdata
);

   ddblc_pkg::cfg_type  cfg_ff, cfg_in;
   ddblc_pkg::desc_type desc;

   logic       in_valid_ff, in_valid_in;
   logic [1:0] op_ff;
   logic       btn_a_ff;
   logic       btn_b_ff;
   logic       ch_ff;
   logic [7:0] val_ff;
   logic       load_ready;
   logic       advance;
   logic       req_take;

   // hold a request in the input register until the result register frees
   assign advance   = in_valid_ff && load_ready;
   assign req_stall = in_valid_ff && !load_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   // config write: each register keeps its own width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            ddblc_pkg::CsrDebounce: cfg_in.debounce_ms   = csr_wdata[9:0];
            ddblc_pkg::CsrRepeat:   cfg_in.repeat_ms     = csr_wdata;
            ddblc_pkg::CsrBlink:    cfg_in.blink_rate    = csr_wdata[7:0];
            ddblc_pkg::CsrLongHold: cfg_in.long_hold_max = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         cfg_ff.debounce_ms   <= ddblc_pkg::DebounceReset;
         cfg_ff.repeat_ms     <= ddblc_pkg::RepeatReset;
         cfg_ff.blink_rate    <= ddblc_pkg::BlinkReset;
         cfg_ff.long_hold_max <= ddblc_pkg::LongHoldReset;
      end else begin
         in_valid_ff <= in_valid_in;
         cfg_ff      <= cfg_in;
      end
   end

   // payload: load on accept, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff    <= req_operation;
         btn_a_ff <= req_button_a;
         btn_b_ff <= req_button_b;
         ch_ff    <= req_channel;
         val_ff   <= req_value;
      end
   end

   ddblc_state u_state (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .operation (op_ff),
      .button_a  (btn_a_ff),
      .button_b  (btn_b_ff),
      .channel   (ch_ff),
      .value     (val_ff),
      .cfg       (cfg_ff),
      .desc      (desc)
   );

   ddblc_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .load_valid      (in_valid_ff),
      .load_desc       (desc),
      .load_ready      (load_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_last        (rsp_last),
      .rsp_led_on      (rsp_led_on),
      .rsp_option_seen (rsp_option_seen),
      .rsp_toggled     (rsp_toggled)
   );

endmodule
